/* rtl/sse_pkg.sv */
// Package for the selection sort engine: word width and sequencer state type.
// No dependencies; used by sse_ram and selection_sort_engine_core.
`default_nettype none

package sse_pkg;

  localparam int unsigned DATA_W = 32;

  typedef enum logic [2:0] {
    ST_LOAD,     // taking words into the store
    ST_RD_HEAD,  // read head of unsorted tail
    ST_HEAD,     // head data back, start scan
    ST_SCAN,     // one compare per cycle over the tail
    ST_SWAP      // write head into min slot, emit min
  } sse_state_e;

endpackage

`default_nettype wire

/* rtl/sse_ram.sv */
// Element store: one write port, one read port, registered read.
// Depends on sse_pkg for the word width.
`default_nettype none

module sse_ram #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                         clk_i,
  input  wire logic                         we_i,
  input  wire logic [$clog2(DEPTH)-1:0]     waddr_i,
  input  wire logic [sse_pkg::DATA_W-1:0]   wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0]     raddr_i,
  output      logic [sse_pkg::DATA_W-1:0]   rdata_o
);

  logic [sse_pkg::DATA_W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

/* rtl/selection_sort_engine_core.sv */
// Selection sort engine top level: load sequencer, scan/swap datapath, output register.
// Depends on sse_pkg and sse_ram.
// Words load at one per cycle. Pass i (i = 0..n-1) of an n-word set does a head read, a
// head capture, one read and compare per tail entry and a swap/emit, serialised by the
// single store read port. Output stalls only stretch the swap cycle. Reset (rst_ni low,
// async) empties the count; store is not cleared.
`default_nettype none

module selection_sort_engine_core #(
  parameter int unsigned DEPTH = 64
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] value
  input  wire logic        s_axis_tlast,   // last_item
  // result stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [31:0] m_axis_tdata,   // [31:0] sorted_value
  output      logic        m_axis_tlast    // last_result
);

  localparam int unsigned AW = $clog2(DEPTH);      // store address
  localparam int unsigned CW = $clog2(DEPTH + 1);  // count, can hold DEPTH

  localparam int unsigned DW = sse_pkg::DATA_W;

  sse_pkg::sse_state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;     // words held in current set
  logic [CW-1:0] n_q, n_d;             // set size being sorted
  logic [AW-1:0] i_q, i_d;             // head of unsorted tail
  logic [CW-1:0] j_q, j_d;             // next tail index to read
  logic [AW-1:0] pidx_q, pidx_d;       // index of read in flight
  logic [AW-1:0] best_idx_q, best_idx_d;
  logic [DW-1:0] best_val_q, best_val_d;
  logic [DW-1:0] head_val_q, head_val_d;

  logic          out_valid_q, out_valid_d;
  logic [DW-1:0] out_data_q, out_data_d;
  logic          out_last_q, out_last_d;

  // store port signals
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [DW-1:0] ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [DW-1:0] ram_rdata;

  logic          s_acc;
  logic          full;
  logic          out_free;
  logic [CW-1:0] i_ext;
  logic [CW-1:0] i_inc;

  assign s_axis_tready = (state_q == sse_pkg::ST_LOAD);
  assign s_acc         = s_axis_tvalid & s_axis_tready;
  assign full          = (count_q == CW'(DEPTH));
  // output register can take a word this cycle
  assign out_free      = ~out_valid_q | m_axis_tready;
  assign i_ext         = CW'(i_q);
  assign i_inc         = i_ext + CW'(1);

  sse_ram #(
    .DEPTH (DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Sequencer. Each pass: read head, scan tail tracking the first minimum
  // (strict less-than keeps the earliest), then write the old head into the
  // minimum's slot and emit the minimum. Slot i itself is never read again,
  // so it needs no write.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    n_d         = n_q;
    i_d         = i_q;
    j_d         = j_q;
    pidx_d      = pidx_q;
    best_idx_d  = best_idx_q;
    best_val_d  = best_val_q;
    head_val_d  = head_val_q;
    out_valid_d = out_valid_q & ~m_axis_tready;
    out_data_d  = out_data_q;
    out_last_d  = out_last_q;
    ram_we      = 1'b0;
    ram_waddr   = count_q[AW-1:0];
    ram_wdata   = s_axis_tdata;
    ram_raddr   = i_q;

    unique case (state_q)
      sse_pkg::ST_LOAD: begin
        if (s_acc) begin
          // words past the store depth are dropped
          if (!full) begin
            ram_we  = 1'b1;
            count_d = count_q + CW'(1);
          end
          if (s_axis_tlast) begin
            n_d     = full ? count_q : count_q + CW'(1);
            i_d     = '0;
            state_d = sse_pkg::ST_RD_HEAD;
          end
        end
      end

      sse_pkg::ST_RD_HEAD: begin
        ram_raddr = i_q;
        state_d   = sse_pkg::ST_HEAD;
      end

      sse_pkg::ST_HEAD: begin
        head_val_d = ram_rdata;
        best_val_d = ram_rdata;
        best_idx_d = i_q;
        if (i_inc < n_q) begin
          ram_raddr = i_inc[AW-1:0];
          pidx_d    = i_inc[AW-1:0];
          j_d       = i_inc + CW'(1);
          state_d   = sse_pkg::ST_SCAN;
        end else begin
          state_d = sse_pkg::ST_SWAP;
        end
      end

      sse_pkg::ST_SCAN: begin
        if ($signed(ram_rdata) < $signed(best_val_q)) begin
          best_val_d = ram_rdata;
          best_idx_d = pidx_q;
        end
        if (j_q < n_q) begin
          ram_raddr = j_q[AW-1:0];
          pidx_d    = j_q[AW-1:0];
          j_d       = j_q + CW'(1);
        end else begin
          state_d = sse_pkg::ST_SWAP;
        end
      end

      sse_pkg::ST_SWAP: begin
        // rewrite while stalled is harmless
        ram_we    = 1'b1;
        ram_waddr = best_idx_q;
        ram_wdata = head_val_q;
        if (out_free) begin
          out_valid_d = 1'b1;
          out_data_d  = best_val_q;
          out_last_d  = (i_inc == n_q);
          if (i_inc == n_q) begin
            count_d = '0;
            state_d = sse_pkg::ST_LOAD;
          end else begin
            i_d     = i_inc[AW-1:0];
            state_d = sse_pkg::ST_RD_HEAD;
          end
        end
      end

      default: begin
        state_d = sse_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sse_pkg::ST_LOAD;
      count_q     <= '0;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      n_q         <= n_d;
      i_q         <= i_d;
      j_q         <= j_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    pidx_q     <= pidx_d;
    best_idx_q <= best_idx_d;
    best_val_q <= best_val_d;
    head_val_q <= head_val_d;
    out_data_q <= out_data_d;
    out_last_q <= out_last_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

endmodule

`default_nettype wire

/* rtl/sse_checker.sv */
// Port-level checker for selection_sort_engine_core, bound to the top level.
// No package dependencies.
`default_nettype none

module sse_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        s_axis_tlast,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [31:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  // stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("result word changed while stalled");

  // end of set closes the input until the sort is done
  a_sort_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
    else $error("input open right after last word of set");

  // only the final result of a set may be pending while loading
  a_mid_set_closed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input open while set still being emitted");

endmodule

bind selection_sort_engine_core sse_checker u_sse_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tlast  (s_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire
